### design/edit_distance_engine_defines.svh
// Assertion macros for the edit distance engine.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef EDIT_DISTANCE_ENGINE_DEFINES_SVH
`define EDIT_DISTANCE_ENGINE_DEFINES_SVH

// Check that a condition holds at every edge.
`define EDE_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check that a condition implies another one at the same edge.
`define EDE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another one at the next edge.
`define EDE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ede_pkg.sv
// Shared types, constants and helper functions of the edit distance engine.
// No dependencies.
package ede_pkg;

    localparam int MAX_LEN   = 64;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int ROW_DEPTH = MAX_LEN + 1;
    localparam int SYM_W     = 8;
    localparam int DIST_W    = 7;
    localparam int OP_W      = 2;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE  = 2'd2;

    typedef logic [LEN_W-1:0] len_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_CELL,
        ST_FINISH
    } state_t;

    // One entry of the row memory: entry j holds symbol j-1 of the second
    // string and the cost cell j of the working row.
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        len_t             cost;
    } row_entry_t;

    function automatic len_t min3(len_t x, len_t y, len_t z);
        len_t m;
        m = x;
        if (y < m) m = y;
        if (z < m) m = z;
        return m;
    endfunction

    function automatic logic [DIST_W-1:0] sat_dist(len_t v);
        if (int'(v) > int'(DIST_MAX)) begin
            return DIST_MAX;
        end
        return DIST_W'(v);
    endfunction

endpackage

### design/edit_distance_engine.sv
// Edit distance engine: Levenshtein distance between two loaded byte strings.
// Throughput: one append per cycle while idle; a compute holds the input until
//   its result is loaded, set by the walk of the row memory (one cell a cycle
//   within a row). A compute on an empty string skips the walk.
// Reset: synchronous, active low; clears lengths, overflow, FSM and output valid.
module edit_distance_engine (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic [1:0] s_tuser,   // [1:0] opcode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [6:0] distance, [7] overflow
);

`include "edit_distance_engine_defines.svh"

    // ------------------------------------------------------------------
    // Storage: first string in its own memory; second string shares the
    // row memory with the working cost row (entry j = symbol j-1, cost j).
    // ------------------------------------------------------------------
    logic [ede_pkg::SYM_W-1:0] first_mem [ede_pkg::MAX_LEN];
    ede_pkg::row_entry_t       row_mem   [ede_pkg::ROW_DEPTH];

    logic [ede_pkg::SYM_W-1:0] first_rdata;
    ede_pkg::row_entry_t       row_rdata;

    // Control state
    ede_pkg::state_t state_reg, state_next;
    ede_pkg::len_t   len_a_reg;
    ede_pkg::len_t   len_b_reg;
    logic            ovf_reg;
    logic            m_tvalid_reg;

    // Walk state and result payload
    ede_pkg::len_t   i_reg;
    ede_pkg::len_t   j_reg;
    ede_pkg::len_t   diag_reg;
    ede_pkg::len_t   left_reg;
    ede_pkg::len_t   last_reg;
    logic [7:0]      m_tdata_reg;

    // Handshake and decode
    logic            in_fire;
    logic            op_a;
    logic            op_b;
    logic            op_compute;
    logic            a_full;
    logic            b_full;
    logic            any_empty;
    logic            out_load;
    logic            row_re;

    // Cell datapath
    ede_pkg::len_t   i_prev;
    ede_pkg::len_t   b_waddr;
    ede_pkg::len_t   up_val;
    ede_pkg::len_t   cell_val;
    logic            sym_match;
    logic            row_last;
    logic            last_row;

    assign in_fire    = s_tvalid && s_tready;
    assign op_a       = (s_tuser == ede_pkg::OP_APPEND_A);
    assign op_b       = (s_tuser == ede_pkg::OP_APPEND_B);
    assign op_compute = (s_tuser == ede_pkg::OP_COMPUTE);
    assign a_full     = (len_a_reg == ede_pkg::LEN_W'(ede_pkg::MAX_LEN));
    assign b_full     = (len_b_reg == ede_pkg::LEN_W'(ede_pkg::MAX_LEN));
    assign any_empty  = (len_a_reg == '0) || (len_b_reg == '0);
    assign row_last   = (j_reg == len_b_reg);
    assign last_row   = (i_reg == len_a_reg);
    assign i_prev     = i_reg - ede_pkg::LEN_W'(1);
    assign b_waddr    = len_b_reg + ede_pkg::LEN_W'(1);

    // One cell of the recurrence. On the first row the row above is the
    // implicit 0..m ramp, so take j instead of the stale memory cost.
    always_comb begin
        up_val    = (i_reg == ede_pkg::LEN_W'(1)) ? j_reg : row_rdata.cost;
        sym_match = (first_rdata == row_rdata.sym);
        cell_val  = sym_match ? diag_reg
                  : ede_pkg::min3(left_reg, up_val, diag_reg) + ede_pkg::LEN_W'(1);
    end

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ede_pkg::ST_IDLE: begin
                if (in_fire && op_compute) begin
                    state_next = any_empty ? ede_pkg::ST_FINISH : ede_pkg::ST_ROW;
                end
            end
            ede_pkg::ST_ROW: begin
                state_next = ede_pkg::ST_CELL;
            end
            ede_pkg::ST_CELL: begin
                if (row_last) begin
                    state_next = last_row ? ede_pkg::ST_FINISH : ede_pkg::ST_ROW;
                end
            end
            ede_pkg::ST_FINISH: begin
                if (out_load) begin
                    state_next = ede_pkg::ST_IDLE;
                end
            end
            default: state_next = ede_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        row_re   = 1'b0;
        unique case (state_reg)
            ede_pkg::ST_IDLE:   s_tready = 1'b1;
            ede_pkg::ST_ROW:    row_re   = 1'b1;
            ede_pkg::ST_CELL:   row_re   = !row_last;
            ede_pkg::ST_FINISH: out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Memories: writes on append and per cell, registered reads
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_fire && op_a && !a_full) begin
            first_mem[len_a_reg[ede_pkg::ADDR_W-1:0]] <= s_tdata;
        end
        // Fetch the row's symbol of the first string once and hold it.
        if (state_reg == ede_pkg::ST_ROW) begin
            first_rdata <= first_mem[i_prev[ede_pkg::ADDR_W-1:0]];
        end
    end

    // Reads of entry j+1 never meet the write of entry j; the next row
    // reads entry 1 in a later cycle than the last write of this row.
    always_ff @(posedge aclk) begin
        if (in_fire && op_b && !b_full) begin
            row_mem[b_waddr].sym <= s_tdata;
        end
        if (state_reg == ede_pkg::ST_CELL) begin
            row_mem[j_reg].cost <= cell_val;
        end
        if (row_re) begin
            row_rdata <= row_mem[(state_reg == ede_pkg::ST_ROW) ?
                                 ede_pkg::LEN_W'(1) : (j_reg + ede_pkg::LEN_W'(1))];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ede_pkg::ST_IDLE;
            len_a_reg    <= '0;
            len_b_reg    <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_fire && op_a) begin
                if (a_full) ovf_reg <= 1'b1;
                else        len_a_reg <= len_a_reg + ede_pkg::LEN_W'(1);
            end
            if (in_fire && op_b) begin
                if (b_full) ovf_reg <= 1'b1;
                else        len_b_reg <= len_b_reg + ede_pkg::LEN_W'(1);
            end
            // Clear both strings and the overflow flag as the result is loaded for output.
            if (out_load) begin
                len_a_reg <= '0;
                len_b_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Walk registers and output payload
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        case (state_reg)
            ede_pkg::ST_IDLE: begin
                i_reg    <= ede_pkg::LEN_W'(1);
                last_reg <= (len_a_reg == '0) ? len_b_reg : len_a_reg;
            end
            ede_pkg::ST_ROW: begin
                // Column zero of the row above is i-1, of this row i.
                j_reg    <= ede_pkg::LEN_W'(1);
                diag_reg <= i_prev;
                left_reg <= i_reg;
            end
            ede_pkg::ST_CELL: begin
                diag_reg <= up_val;
                left_reg <= cell_val;
                last_reg <= cell_val;
                if (row_last) begin
                    i_reg <= i_reg + ede_pkg::LEN_W'(1);
                end else begin
                    j_reg <= j_reg + ede_pkg::LEN_W'(1);
                end
            end
            default: ;
        endcase
        if (out_load) begin
            m_tdata_reg <= {ovf_reg, ede_pkg::sat_dist(last_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `EDE_ASSERT_ALWAYS(a_len_bound, (len_a_reg <= ede_pkg::LEN_W'(ede_pkg::MAX_LEN)) && (len_b_reg <= ede_pkg::LEN_W'(ede_pkg::MAX_LEN)), "string length beyond capacity")
    `EDE_ASSERT_IMPL(a_cell_range, state_reg == ede_pkg::ST_CELL, (j_reg != '0) && (j_reg <= len_b_reg) && (i_reg != '0) && (i_reg <= len_a_reg), "cell index out of range")
    `EDE_ASSERT_IMPL(a_load_src, $rose(m_tvalid_reg), $past(state_reg == ede_pkg::ST_FINISH), "result loaded outside finish")
    `EDE_ASSERT_NEXT(a_clear_after, out_load, (len_a_reg == '0) && (len_b_reg == '0) && !ovf_reg, "strings not cleared after result")
    `EDE_ASSERT_IMPL(a_dist_bound, m_tvalid_reg, int'(m_tdata_reg[6:0]) <= ede_pkg::MAX_LEN, "distance exceeds longest string")

endmodule

### tb/sv/tb_edit_distance_engine.sv
// Self-checking testbench for edit_distance_engine: loads string pairs, computes
// the expected Levenshtein distance and overflow flag, and checks every result.
// Depends on ede_pkg and the edit_distance_engine RTL.
`timescale 1ns / 100ps

module tb_edit_distance_engine;

    import ede_pkg::*;

    // Opcode 3 has no meaning in the block; it must be accepted and ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 1550;
    // The longest silent stretch is a full 64x64 walk plus a receiver stall;
    // allow several times that.
    localparam int IDLE_LIMIT  = 30000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        bit               hold;   // wait for every pending result before sending
    } request_t;

    typedef struct packed {
        logic              overflow;
        logic [DIST_W-1:0] distance;
    } distance_result_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] symbol
    logic [1:0] s_tuser  = '0;   // [1:0] opcode
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [6:0] distance, [7] overflow

    request_t         pending_requests[$];
    distance_result_t expected_distances[$];

    // Shadow copy of the block's string storage.
    logic [SYM_W-1:0] first_str [MAX_LEN];
    logic [SYM_W-1:0] second_str[MAX_LEN];
    int               first_len;
    int               second_len;
    bit               dropped_append;

    int items_planned     = 0;
    int requests_total    = 0;
    int requests_accepted = 0;
    int fail_count        = 0;

    edit_distance_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Distance between the shadow strings, one row at a time. A matching symbol
    // carries the diagonal; otherwise take one plus the least of left, up, diag.
    function automatic logic [DIST_W-1:0] edit_distance_of();
        int row_prev[MAX_LEN+1];
        int row_cur [MAX_LEN+1];
        int best;
        for (int j = 0; j <= second_len; j++) row_prev[j] = j;
        for (int i = 1; i <= first_len; i++) begin
            row_cur[0] = i;
            for (int j = 1; j <= second_len; j++) begin
                if (first_str[i-1] == second_str[j-1]) begin
                    row_cur[j] = row_prev[j-1];
                end else begin
                    best = row_prev[j-1];
                    if (row_prev[j] < best) best = row_prev[j];
                    if (row_cur[j-1] < best) best = row_cur[j-1];
                    row_cur[j] = best + 1;
                end
            end
            row_prev = row_cur;
        end
        // Saturate; only reachable if the capacity is raised past the field width.
        if (row_prev[second_len] > int'(DIST_MAX)) return DIST_MAX;
        return DIST_W'(row_prev[second_len]);
    endfunction

    // Apply one accepted request to the shadow state; a compute queues a result
    // and clears both strings and the overflow flag.
    function automatic void absorb_request(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym);
        distance_result_t res;
        case (op)
            OP_APPEND_A: begin
                if (first_len < MAX_LEN) begin
                    first_str[first_len] = sym;
                    first_len++;
                end else begin
                    dropped_append = 1'b1;
                end
            end
            OP_APPEND_B: begin
                if (second_len < MAX_LEN) begin
                    second_str[second_len] = sym;
                    second_len++;
                end else begin
                    dropped_append = 1'b1;
                end
            end
            OP_COMPUTE: begin
                res.distance = edit_distance_of();
                res.overflow = dropped_append;
                expected_distances.push_back(res);
                first_len      = 0;
                second_len     = 0;
                dropped_append = 1'b0;
            end
            default: begin
                // unused opcode: drop silently
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------

    function automatic void queue_request(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                          bit hold = 1'b0);
        request_t req;
        req.op   = op;
        req.sym  = sym;
        req.hold = hold;
        pending_requests.push_back(req);
        requests_total++;
        if (op != OP_UNUSED) items_planned++;
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 85) return $urandom_range(0, 8);
        if (roll < 97) return $urandom_range(9, 24);
        return $urandom_range(MAX_LEN - 4, MAX_LEN + 4);   // near and past capacity
    endfunction

    // Build one string pair with random content, interleave the appends, then
    // compute. A small alphabet makes matches and ties common; a mutated copy
    // keeps the distance small against long strings. A few sequences are
    // broken: the compute is skipped, a noise opcode slips in, or an extra
    // compute on empty strings follows.
    function automatic void queue_random_pair();
        logic [SYM_W-1:0] seq_a[$];
        logic [SYM_W-1:0] seq_b[$];
        logic [SYM_W-1:0] base;
        int               n_a;
        int               style;
        int               roll;
        bit               hold;
        bit               take_a;
        n_a   = pick_length();
        style = $urandom_range(0, 2);
        base  = SYM_W'($urandom);
        for (int k = 0; k < n_a; k++) begin
            seq_a.push_back(style == 0 ? SYM_W'($urandom) : base + SYM_W'($urandom_range(0, 3)));
        end
        if (style == 2) begin
            foreach (seq_a[k]) begin
                roll = $urandom_range(0, 9);
                if (roll == 1) begin
                    seq_b.push_back(base + SYM_W'($urandom_range(0, 3)));
                end else if (roll == 2) begin
                    seq_b.push_back(base + SYM_W'($urandom_range(0, 3)));
                    seq_b.push_back(seq_a[k]);
                end else if (roll != 0) begin
                    seq_b.push_back(seq_a[k]);
                end
            end
        end else begin
            repeat (pick_length()) begin
                seq_b.push_back(style == 0 ? SYM_W'($urandom)
                                           : base + SYM_W'($urandom_range(0, 3)));
            end
        end
        hold = ($urandom_range(0, 11) == 0);
        while (seq_a.size() != 0 || seq_b.size() != 0) begin
            take_a = (seq_b.size() == 0) || (seq_a.size() != 0 && $urandom_range(0, 1) == 1);
            if ($urandom_range(0, 32) == 0) begin
                queue_request(OP_UNUSED, SYM_W'($urandom), hold);
                hold = 1'b0;
            end
            if (take_a) queue_request(OP_APPEND_A, seq_a.pop_front(), hold);
            else        queue_request(OP_APPEND_B, seq_b.pop_front(), hold);
            hold = 1'b0;
        end
        roll = $urandom_range(0, 99);
        if (roll >= 5) queue_request(OP_COMPUTE, SYM_W'($urandom), hold);
        if (roll >= 96) queue_request(OP_COMPUTE, SYM_W'($urandom));
    endfunction

    initial begin
        first_len      = 0;
        second_len     = 0;
        dropped_append = 1'b0;

        // Directed: both strings empty.
        queue_request(OP_COMPUTE, 8'h00);
        // Only the first string loaded, extreme symbols.
        queue_request(OP_APPEND_A, 8'h00);
        queue_request(OP_APPEND_A, 8'hFF);
        queue_request(OP_COMPUTE, 8'hFF);
        // Only the second string loaded.
        queue_request(OP_APPEND_B, 8'hFF);
        queue_request(OP_COMPUTE, 8'h00);
        // Identical single symbols.
        queue_request(OP_APPEND_A, 8'hA5);
        queue_request(OP_APPEND_B, 8'hA5);
        queue_request(OP_COMPUTE, 8'h5A);
        // Zero bytes compare like any other symbol.
        queue_request(OP_APPEND_A, 8'h00);
        queue_request(OP_APPEND_B, 8'h00);
        queue_request(OP_APPEND_A, 8'h01);
        queue_request(OP_APPEND_B, 8'h02);
        queue_request(OP_COMPUTE, 8'h00);
        // Unused opcode leaves the state alone.
        queue_request(OP_UNUSED, 8'hFF);
        queue_request(OP_APPEND_A, 8'h5A);
        queue_request(OP_UNUSED, 8'h00);
        queue_request(OP_COMPUTE, 8'h00);
        // Swapped pair: ties among the three neighbors.
        queue_request(OP_APPEND_A, 8'h61);
        queue_request(OP_APPEND_A, 8'h62);
        queue_request(OP_APPEND_B, 8'h62);
        queue_request(OP_APPEND_B, 8'h61);
        queue_request(OP_COMPUTE, 8'h00, 1'b1);

        // Fill both strings past capacity with disjoint symbols: the largest
        // distance, with the overflow flag raised by both sides.
        for (int k = 0; k <= MAX_LEN; k++) begin
            queue_request(OP_APPEND_A, 8'h00);
            queue_request(OP_APPEND_B, 8'hFF);
        end
        queue_request(OP_COMPUTE, 8'hFF);

        while (items_planned < ITEM_TARGET) queue_random_pair();
    end

    // ------------------------------------------------------------------
    // Reset and end of run
    // ------------------------------------------------------------------

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // Hold until every request is taken, then drain the results and let
        // any trailing activity settle.
        @(posedge aclk);
        while (requests_accepted < requests_total) @(posedge aclk);
        while (expected_distances.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_edit_distance_engine OK");
        end else begin
            $display("tb_edit_distance_engine NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------

    int burst_left = 8;
    int gap_left   = 0;

    always @(posedge aclk) begin : request_driver
        logic     nxt_valid;
        request_t req;
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left = 8;
            gap_left   = 0;
        end else begin
            nxt_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                absorb_request(s_tuser, s_tdata);
                requests_accepted++;
                nxt_valid = 1'b0;
            end
            // Keep the current request on the bus until it is taken; otherwise
            // advance to the next one unless in a gap or held for a drain.
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() != 0 &&
                             !(pending_requests[0].hold && expected_distances.size() != 0)) begin
                    req = pending_requests.pop_front();
                    s_tdata   <= req.sym;
                    s_tuser   <= req.op;
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // A third of the bursts run back to back with no gap.
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                        burst_left = $urandom_range(1, 24);
                    end
                end
            end
            s_tvalid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: ready follows randomly chosen stall modes
    // ------------------------------------------------------------------

    int          stall_mode = 0;
    int          stall_left = 0;
    int unsigned stall_tick = 0;

    always @(posedge aclk) begin : result_monitor
        distance_result_t want;
        logic             nxt_ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_distances.size() == 0) begin
                    $error("unexpected result: m_tdata=%02h", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_distances.pop_front();
                    if (m_tdata[DIST_W-1:0] !== want.distance) begin
                        $error("distance: expected %0d, actual %0d",
                               want.distance, m_tdata[DIST_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[DIST_W] !== want.overflow) begin
                        $error("overflow: expected %0d, actual %0d",
                               want.overflow, m_tdata[DIST_W]);
                        fail_count++;
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(32, 400);
            end else begin
                stall_left--;
            end
            stall_tick++;
            case (stall_mode)
                0:       nxt_ready = 1'b1;
                1:       nxt_ready = $urandom_range(0, 1);
                2:       nxt_ready = ($urandom_range(0, 7) == 0);
                default: nxt_ready = (stall_tick % 8) < 3;
            endcase
            m_tready <= nxt_ready;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on either side for too long
    // ------------------------------------------------------------------

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_edit_distance_engine NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
